// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the deque RTL.
// Both macros expect a clock named clock and an active-high reset named reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define BDQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// The expression must never be true outside reset.
`define BDQ_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) else $error(msg);

`endif

// ===== sv/bdq_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bounded deque package
// Sizes, request and status codes, beat types and ring index helper.
// ---------------------------------------------------------------------------
package bdq_pkg;

   localparam int DEPTH  = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 8;
   localparam int DATA_W = 32;

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
   localparam logic [2:0] KIND_POP_BACK   = 3'd3;
   localparam logic [2:0] KIND_REMOVE_AT  = 3'd4;

   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;
   localparam logic [1:0] STAT_POSZ  = 2'd3;

   typedef struct packed {
      logic [2:0]               kind;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] removed_value;
      logic                     removed_valid;
      logic [1:0]               status;
      logic [CNT_W-1:0]         entry_count_out;
   } rsp_type;

   // Ring slot of the entry at a given offset from the front.
   function automatic logic [ADDR_W-1:0] ring_at(input logic [ADDR_W-1:0] base,
                                                 input logic [CNT_W-1:0]  offset);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(offset);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

// ===== sv/bounded_deque_with_positional_delete_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Bounded double-ended queue with positional delete
// Ring of signed 32-bit entries in one synchronous memory. Pushes and pops at
// either end, plus removal at a 1-based position with the tail closed up.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake              Beat
//  req       in   req_valid / req_stall  kind, value, position
//  rsp       out  rsp_valid / rsp_stall  removed_value, removed_valid, status, count
//
// Every request ends in the response state FIN; a pop passes a capture state
// for the memory read first. Removal runs the 8-step restoring modulo, ends
// there with status POSZ when the position reduces to zero, else captures the
// entry and moves each later entry one place forward, one memory read/write each.
// Reset clears the count, the front pointer and all handshake state; the
// memory holds no reset value. A new request is taken while a finished
// response waits on rsp_stall; its own response then waits for the slot.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_deque_with_positional_delete_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  bdq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output bdq_pkg::rsp_type  rsp_data
);

   localparam int ADDR_W = bdq_pkg::ADDR_W;
   localparam int CNT_W  = bdq_pkg::CNT_W;
   localparam int POS_W  = bdq_pkg::POS_W;
   localparam int DATA_W = bdq_pkg::DATA_W;
   localparam int STEP_W = $clog2(POS_W);

   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(POS_W - 1);
   localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(bdq_pkg::DEPTH);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_DIV   = 3'd1;
   localparam logic [2:0] ST_CAPT  = 3'd2;
   localparam logic [2:0] ST_SHIFT = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   // Entry memory with registered read data.
   logic [DATA_W-1:0] mem [bdq_pkg::DEPTH];
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_wa;
   logic [ADDR_W-1:0] mem_ra;
   logic [DATA_W-1:0] mem_wd;
   logic [DATA_W-1:0] rd_ff;

   logic [2:0]         state_ff,  state_in;
   logic [ADDR_W-1:0]  front_ff,  front_in;
   logic [CNT_W-1:0]   cnt_ff,    cnt_in;
   logic [2:0]         kind_ff,   kind_in;
   logic [POS_W-1:0]   pos_ff,    pos_in;
   logic [STEP_W-1:0]  step_ff,   step_in;
   logic [CNT_W-1:0]   div_r_ff,  div_r_in;
   logic [CNT_W-1:0]   sh_ff,     sh_in;
   logic [DATA_W-1:0]  rem_ff,    rem_in;
   logic               rv_ff,     rv_in;
   logic [1:0]         status_ff, status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   bdq_pkg::rsp_type   rsp_ff,    rsp_in;

   logic [CNT_W:0]   div_t;
   logic [CNT_W:0]   div_d;
   logic [CNT_W-1:0] div_r_next;
   logic             accept;
   logic             rsp_load;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_load  = (state_ff == ST_FIN) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // One restoring step of position mod (count + 1).
   always_comb begin
      div_t = {div_r_ff, pos_ff[POS_W-1]};
      div_d = (CNT_W+1)'(cnt_ff) + (CNT_W+1)'(1);
      if (div_t >= div_d) begin
         div_r_next = CNT_W'(div_t - div_d);
      end else begin
         div_r_next = div_t[CNT_W-1:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      front_in  = front_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;
      pos_in    = pos_ff;
      step_in   = step_ff;
      div_r_in  = div_r_ff;
      sh_in     = sh_ff;
      rem_in    = rem_ff;
      rv_in     = rv_ff;
      status_in = status_ff;
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_wa    = '0;
      mem_ra    = '0;
      mem_wd    = req_data.value;
      rsp_in    = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               kind_in   = req_data.kind;
               pos_in    = req_data.position;
               rv_in     = 1'b0;
               status_in = bdq_pkg::STAT_OK;
               state_in  = ST_FIN;
               case (req_data.kind)
                  bdq_pkg::KIND_PUSH_FRONT: begin
                     if (cnt_ff == CNT_FULL) begin
                        status_in = bdq_pkg::STAT_FULL;
                     end else begin
                        front_in = bdq_pkg::ring_at(front_ff, CNT_W'(bdq_pkg::DEPTH - 1));
                        mem_we   = 1'b1;
                        mem_wa   = front_in;
                        cnt_in   = cnt_ff + CNT_ONE;
                     end
                  end
                  bdq_pkg::KIND_PUSH_BACK: begin
                     if (cnt_ff == CNT_FULL) begin
                        status_in = bdq_pkg::STAT_FULL;
                     end else begin
                        mem_we = 1'b1;
                        mem_wa = bdq_pkg::ring_at(front_ff, cnt_ff);
                        cnt_in = cnt_ff + CNT_ONE;
                     end
                  end
                  bdq_pkg::KIND_POP_FRONT: begin
                     if (cnt_ff == '0) begin
                        status_in = bdq_pkg::STAT_EMPTY;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = front_ff;
                        front_in = bdq_pkg::ring_at(front_ff, CNT_ONE);
                        cnt_in   = cnt_ff - CNT_ONE;
                        rv_in    = 1'b1;
                        state_in = ST_CAPT;
                     end
                  end
                  bdq_pkg::KIND_POP_BACK: begin
                     if (cnt_ff == '0) begin
                        status_in = bdq_pkg::STAT_EMPTY;
                     end else begin
                        mem_re   = 1'b1;
                        mem_ra   = bdq_pkg::ring_at(front_ff, cnt_ff - CNT_ONE);
                        cnt_in   = cnt_ff - CNT_ONE;
                        rv_in    = 1'b1;
                        state_in = ST_CAPT;
                     end
                  end
                  bdq_pkg::KIND_REMOVE_AT: begin
                     if (cnt_ff == '0) begin
                        status_in = bdq_pkg::STAT_EMPTY;
                     end else begin
                        div_r_in = '0;
                        step_in  = '0;
                        state_in = ST_DIV;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DIV: begin
            pos_in   = {pos_ff[POS_W-2:0], 1'b0};
            div_r_in = div_r_next;
            step_in  = step_ff + STEP_W'(1);
            if (step_ff == STEP_LAST) begin
               if (div_r_next == '0) begin
                  status_in = bdq_pkg::STAT_POSZ;
                  state_in  = ST_FIN;
               end else begin
                  mem_re   = 1'b1;
                  mem_ra   = bdq_pkg::ring_at(front_ff, div_r_next - CNT_ONE);
                  rv_in    = 1'b1;
                  state_in = ST_CAPT;
               end
            end
         end
         ST_CAPT: begin
            rem_in   = rd_ff;
            state_in = ST_FIN;
            if (kind_ff == bdq_pkg::KIND_REMOVE_AT) begin
               // div_r_ff holds the 1-based position k of the removed entry.
               if (div_r_ff < cnt_ff) begin
                  mem_re   = 1'b1;
                  mem_ra   = bdq_pkg::ring_at(front_ff, div_r_ff);
                  sh_in    = div_r_ff;
                  state_in = ST_SHIFT;
               end else begin
                  cnt_in = cnt_ff - CNT_ONE;
               end
            end
         end
         ST_SHIFT: begin
            // rd_ff holds the entry at offset sh_ff; move it one place forward.
            mem_we = 1'b1;
            mem_wa = bdq_pkg::ring_at(front_ff, sh_ff - CNT_ONE);
            mem_wd = rd_ff;
            if ((sh_ff + CNT_ONE) < cnt_ff) begin
               mem_re = 1'b1;
               mem_ra = bdq_pkg::ring_at(front_ff, sh_ff + CNT_ONE);
               sh_in  = sh_ff + CNT_ONE;
            end else begin
               cnt_in   = cnt_ff - CNT_ONE;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (rsp_load) begin
               rsp_in.removed_value = rv_ff ? rem_ff : '0;
               rsp_in.removed_valid = rv_ff;
               rsp_in.status        = status_ff;
               rsp_in.entry_count_out = cnt_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         front_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         front_ff     <= front_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      pos_ff    <= pos_in;
      step_ff   <= step_in;
      div_r_ff  <= div_r_in;
      sh_ff     <= sh_in;
      rem_ff    <= rem_in;
      rv_ff     <= rv_in;
      status_ff <= status_in;
      rsp_ff    <= rsp_in;
   end

   `BDQ_ASSERT(a_count_bound, cnt_ff <= CNT_FULL, "entry count above depth")
   `BDQ_ASSERT(a_shift_range, (state_ff == ST_SHIFT) |-> (sh_ff < cnt_ff), "shift beyond tail")
   `BDQ_NEVER(a_port_clash, mem_we && mem_re && (mem_wa == mem_ra), "read and write same slot")
   `BDQ_ASSERT(a_removal_ok, (rsp_valid && rsp_data.removed_valid) |-> (rsp_data.status == bdq_pkg::STAT_OK), "removal with error status")

endmodule
